[src/dsi2c_pkg.sv]
// Shared types, constants and widths for the display I2C write sequencer.
`timescale 1ns / 1ps
`default_nettype none
package dsi2c_pkg;

	localparam int unsigned OP_W       = 2;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned TICK_W     = 5;
	localparam int unsigned IDX_W      = 2;
	localparam int unsigned S_TDATA_W  = 16;
	localparam int unsigned M_TDATA_W  = 8;

	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_CMD   = 2'd1;
	localparam logic [OP_W-1:0] OP_DATA  = 2'd2;
	localparam logic [OP_W-1:0] OP_PROBE = 2'd3;

	localparam logic [BYTE_W-1:0] CTRL_CMD   = 8'h00;
	localparam logic [BYTE_W-1:0] CTRL_DATA  = 8'h40;
	localparam logic [BYTE_W-1:0] ADDR_RESET = 8'd120;

	localparam logic [TICK_W-1:0] ACK_HIGH_TICK = 5'd16;
	localparam logic [TICK_W-1:0] ACK_LOW_TICK  = 5'd17;

	localparam logic [IDX_W-1:0] IDX_ADDR    = 2'd0;
	localparam logic [IDX_W-1:0] IDX_CTRL    = 2'd1;
	localparam logic [IDX_W-1:0] IDX_PAYLOAD = 2'd2;

	localparam int unsigned OUT_SCL  = 0;
	localparam int unsigned OUT_SDA  = 1;
	localparam int unsigned OUT_BUSY = 2;
	localparam int unsigned OUT_DONE = 3;
	localparam int unsigned OUT_ACK  = 4;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_BYTE  = 2'd2,
		PH_STOP  = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [IDX_W-1:0]  byte_index;
		logic [TICK_W-1:0] bit_tick;
		logic [BYTE_W-1:0] shift_byte;
		logic [BYTE_W-1:0] held_payload;
		logic [OP_W-1:0]   held_operation;
		logic              address_acked;
	} seq_state_t;

	typedef struct packed {
		logic ack_ok;
		logic done_res;
		logic busy_res;
		logic sda_level;
		logic scl_level;
	} tick_res_t;

	localparam seq_state_t STATE_RESET = '{
		phase:          PH_IDLE,
		byte_index:     '0,
		bit_tick:       '0,
		shift_byte:     '0,
		held_payload:   '0,
		held_operation: OP_TICK,
		address_acked:  1'b0
	};

endpackage
`default_nettype wire

[src/dsi2c_step.sv]
// Next-state and line-level logic for one bus tick of the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module dsi2c_step
	import dsi2c_pkg::*;
(
	input  seq_state_t        cur,
	input  logic [OP_W-1:0]   operation,
	input  logic [BYTE_W-1:0] payload,
	input  logic              sda_in,
	input  logic [BYTE_W-1:0] device_address,
	output seq_state_t        nxt,
	output tick_res_t         res
);

	always_comb begin
		nxt = cur;
		res = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
			done_res: 1'b0, ack_ok: 1'b0};

		if (cur.phase == PH_IDLE && operation != OP_TICK) begin
			nxt.held_operation = operation;
			nxt.held_payload   = payload;
			nxt.shift_byte     = device_address;
			nxt.address_acked  = 1'b0;
			nxt.byte_index     = IDX_ADDR;
			nxt.bit_tick       = '0;
			nxt.phase          = PH_START;
		end

		unique case (nxt.phase)
			PH_IDLE: begin
			end
			PH_START: begin
				res.busy_res = 1'b1;
				if (nxt.bit_tick == '0) begin
					nxt.bit_tick = 5'd1;
				end else begin
					res.sda_level  = 1'b0;
					nxt.phase      = PH_BYTE;
					nxt.byte_index = IDX_ADDR;
					nxt.bit_tick   = '0;
				end
			end
			PH_BYTE: begin
				res.busy_res = 1'b1;
				if (nxt.bit_tick < ACK_HIGH_TICK) begin
					res.sda_level = nxt.shift_byte[BYTE_W-1];
					res.scl_level = ~nxt.bit_tick[0];
					if (nxt.bit_tick[0]) begin
						nxt.shift_byte = {nxt.shift_byte[BYTE_W-2:0], 1'b0};
					end
					nxt.bit_tick = nxt.bit_tick + 5'd1;
				end else if (nxt.bit_tick == ACK_HIGH_TICK) begin
					if (nxt.byte_index == IDX_ADDR) begin
						nxt.address_acked = ~sda_in;
					end
					nxt.bit_tick = ACK_LOW_TICK;
				end else begin
					res.scl_level = 1'b0;
					nxt.bit_tick  = '0;
					if (nxt.held_operation == OP_PROBE || nxt.byte_index >= IDX_PAYLOAD) begin
						nxt.phase      = PH_STOP;
						nxt.byte_index = IDX_ADDR;
					end else if (nxt.byte_index == IDX_ADDR) begin
						nxt.byte_index = IDX_CTRL;
						nxt.shift_byte = (nxt.held_operation == OP_DATA) ? CTRL_DATA : CTRL_CMD;
					end else begin
						nxt.byte_index = IDX_PAYLOAD;
						nxt.shift_byte = nxt.held_payload;
					end
				end
			end
			PH_STOP: begin
				res.busy_res = 1'b1;
				if (nxt.bit_tick == '0) begin
					res.sda_level = 1'b0;
					nxt.bit_tick  = 5'd1;
				end else begin
					res.done_res = 1'b1;
					res.ack_ok   = nxt.address_acked;
					nxt.phase    = PH_IDLE;
					nxt.bit_tick = '0;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[src/display_i2c_write_sequencer.sv]
// Top level of the display I2C write sequencer: stream ports, state and result register.
// A result item is valid in the cycle after its tick item is accepted.
// One tick item per cycle unless m_tready stalls; result register frees when it is taken.
// The tick logic is a single pass over the held sequencer state, no iteration.
// Reset: sequencer idle, device address 120, result register empty.
`timescale 1ns / 1ps
`default_nettype none
module display_i2c_write_sequencer
	import dsi2c_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [BYTE_W-1:0]    cfg_wdata,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // [7:0] payload, [8] sda_in, [15:9] zero
	input  wire logic [OP_W-1:0]      s_tuser,  // [1:0] operation
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [M_TDATA_W-1:0] m_tdata   // [0] scl_level, [1] sda_level, [2] busy_res,
	                                            // [3] done_res, [4] ack_ok, [7:5] zero
);

	logic [BYTE_W-1:0]    addr_q;
	seq_state_t           state_q;
	seq_state_t           state_nxt;
	tick_res_t            res_nxt;
	tick_res_t            res_q;
	logic                 m_valid_q;
	logic                 accept;

	assign s_tready = ~m_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_W - $bits(tick_res_t)){1'b0}}, res_q};

	dsi2c_step u_step (
		.cur            (state_q),
		.operation      (s_tuser),
		.payload        (s_tdata[BYTE_W-1:0]),
		.sda_in         (s_tdata[BYTE_W]),
		.device_address (addr_q),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (cfg_wen) begin
			addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= STATE_RESET;
			m_valid_q <= 1'b0;
		end else if (accept) begin
			state_q   <= state_nxt;
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

endmodule
`default_nettype wire

[src/dsi2c_checker.sv]
// Port-level assertions for the display I2C write sequencer, with their bind.
`timescale 1ns / 1ps
`default_nettype none
module dsi2c_checker
	import dsi2c_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result item changed");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with free result register");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_DONE] |-> m_tdata[OUT_BUSY])
		else $error("done outside a transaction");

	a_ack_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_ACK] |-> m_tdata[OUT_DONE])
		else $error("ack_ok outside done");

	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_DONE] |-> m_tdata[OUT_SCL] && m_tdata[OUT_SDA])
		else $error("lines not released on stop");

endmodule

bind display_i2c_write_sequencer dsi2c_checker u_dsi2c_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
